// ===== hw/rtl/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg: shared types and codes of the shifting list store
// command and status codes, word width and the per-cell control group
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCOUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_POP_END    = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_INSERT_MID = 3'd4,
    CMD_REMOVE_MID = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // move command broadcast to every cell in the row
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sls_cell.sv =====
// ----------------------------------------------------------------------------
// sls_cell: one word of the list
// holds, loads the new word or takes a neighbour's word, by its place
// relative to the pivot cell
// ----------------------------------------------------------------------------
module sls_cell #(
  parameter int unsigned CntW  = 7,
  parameter int unsigned Index = 0
) (
  input  logic                              clk_i,
  input  sls_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CntW-1:0]                   pivot_i,
  input  logic [sls_pkg::WORD_W-1:0]        new_word_i,
  input  logic [sls_pkg::WORD_W-1:0]        lo_word_i,
  input  logic [sls_pkg::WORD_W-1:0]        hi_word_i,
  output logic [sls_pkg::WORD_W-1:0]        word_o
);
  import sls_pkg::*;

  localparam logic [CntW-1:0] Pos = CntW'(Index);

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (Pos > pivot_i) begin
        word_d = lo_word_i;
      end else if (Pos == pivot_i) begin
        word_d = new_word_i;
      end
    end else if (ctrl_i.rem) begin
      if (Pos >= pivot_i) begin
        word_d = hi_word_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== hw/rtl/shifting_list_store.sv =====
// ----------------------------------------------------------------------------
// shifting_list_store: bounded ordered list of signed words in a row of cells
// append, pop, insert or remove at an index or at the middle, one result each
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)                       width
//  s_axis    in   cmd[2:0] position[8:3] item_value[40:9]         48
//  m_axis    out  popped_value[31:0] status[33:32] count[40:34]   48
//
//  one item per cycle unless stalled (see below); the result is registered
//  the list is stored end-first: the last element always sits in cell 0, so
//  every insert or remove is one shift of part of the row
//  rst_ni clears the count and m_valid_q; cells and result data are not reset
//  a waiting result stalls input only while m_axis_tready is low
// ----------------------------------------------------------------------------
module shifting_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd, position, item_value, zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // popped_value, status, element_count, zero pad
  output logic [47:0] m_axis_tdata
);
  import sls_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0]   count_q, count_d;
  logic              m_valid_q;
  logic [WORD_W-1:0] popped_q, popped_d;
  status_e           status_q, status_d;

  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] item_value;
  logic              accept;

  cell_ctrl_t        ctrl;
  logic [CntW-1:0]   pivot;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   cnt_ext;
  logic [WORD_W-1:0] cell_word [CAPACITY];

  assign cmd        = s_axis_tdata[2:0];
  assign position   = s_axis_tdata[8:3];
  assign item_value = s_axis_tdata[40:9];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cnt_ext       = IdxW'(count_q);

  always_comb begin
    ctrl     = '0;
    pivot    = '0;
    idx      = '0;
    count_d  = count_q;
    popped_d = '0;
    status_d = ST_OK;
    case (cmd)
      CMD_APPEND:     idx = cnt_ext;
      CMD_INSERT_AT:  idx = IdxW'(position);
      CMD_REMOVE_AT:  idx = IdxW'(position);
      CMD_INSERT_MID: idx = cnt_ext >> 1;
      CMD_REMOVE_MID: idx = cnt_ext >> 1;
      default:        idx = '0;
    endcase
    case (cmd)
      CMD_APPEND, CMD_INSERT_AT, CMD_INSERT_MID: begin
        if (idx > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (count_q >= CapCnt) begin
          status_d = ST_FULL;
        end else begin
          // logical index idx lands in cell count - idx
          ctrl.ins = accept;
          pivot    = count_q - CntW'(idx);
          count_d  = count_q + CntW'(1);
        end
      end
      CMD_REMOVE_AT, CMD_REMOVE_MID: begin
        if (idx >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.rem = accept;
          pivot    = count_q - CntW'(1) - CntW'(idx);
          count_d  = count_q - CntW'(1);
        end
      end
      CMD_POP_END: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          // the end of the list is always cell 0
          ctrl.rem = accept;
          pivot    = '0;
          popped_d = cell_word[0];
          count_d  = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;
    if (j == 0) begin : g_first
      assign lo_word = '0;
    end else begin : g_lo
      assign lo_word = cell_word[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign hi_word = cell_word[j];
    end else begin : g_hi
      assign hi_word = cell_word[j+1];
    end
    sls_cell #(
      .CntW  (CntW),
      .Index (j)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .pivot_i    (pivot),
      .new_word_i (item_value),
      .lo_word_i  (lo_word),
      .hi_word_i  (hi_word),
      .word_o     (cell_word[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, OCOUNT_W'(count_q), status_q, popped_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("element count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d != ST_OK |=> count_q == $past(count_q))
    else $error("failed command changed the count");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && status_q == ST_EMPTY |-> count_q == '0 && popped_q == '0)
    else $error("empty status with elements held");

  a_single_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove at once");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_valid_q && !m_axis_tready)
    else $error("input stalled without a waiting result");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for shifting_list_store
// directed table then biased random fill/drain runs, each result checked
// against its table row or a behavioural list, with random stalls both sides
// ----------------------------------------------------------------------------
module tb;
  import sls_pkg::*;

  localparam int unsigned LIST_CAPACITY  = 64;
  localparam int unsigned RANDOM_ITEMS   = 1230;
  localparam int unsigned DRAIN_EVERY    = 250;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_GAP        = 17;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // field order matches m_axis_tdata from the top bit down
  typedef struct packed {
    logic [OCOUNT_W-1:0] element_count;
    status_e             status;
    logic [WORD_W-1:0]   popped_value;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] item_value;
    logic              typed;
    list_result_t      want;
  } list_row_t;

  localparam int unsigned N_ROWS = 21;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cmd, position, item_value, zero pad
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // popped_value, status, element_count, zero pad
  logic [47:0] m_axis_tdata;

  // behavioural copy of the list
  logic [WORD_W-1:0] list_words [LIST_CAPACITY];
  int unsigned       list_len;

  list_result_t expected_results [$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  bit           src_burst;
  bit           sink_burst;

  list_row_t directed_rows [N_ROWS] = '{
    '{CMD_POP_END,    6'd0,  32'h0000_0000, 1'b1, '{7'd0, ST_EMPTY, 32'h0}},
    '{CMD_REMOVE_AT,  6'd0,  32'h0000_0000, 1'b1, '{7'd0, ST_RANGE, 32'h0}},
    '{CMD_REMOVE_MID, 6'd0,  32'h0000_0000, 1'b1, '{7'd0, ST_RANGE, 32'h0}},
    '{CMD_INSERT_AT,  6'd63, 32'h0000_0001, 1'b1, '{7'd0, ST_RANGE, 32'h0}},
    '{CMD_INSERT_AT,  6'd1,  32'h0000_0001, 1'b1, '{7'd0, ST_RANGE, 32'h0}},
    '{CMD_APPEND,     6'd0,  32'h7fff_ffff, 1'b1, '{7'd1, ST_OK,    32'h0}},
    '{CMD_INSERT_AT,  6'd0,  32'h8000_0000, 1'b1, '{7'd2, ST_OK,    32'h0}},
    '{CMD_INSERT_MID, 6'd63, 32'hffff_ffff, 1'b1, '{7'd3, ST_OK,    32'h0}},
    '{CMD_SPARE_LO,   6'd0,  32'h0000_0000, 1'b1, '{7'd3, ST_OK,    32'h0}},
    '{CMD_SPARE_HI,   6'd63, 32'hffff_ffff, 1'b1, '{7'd3, ST_OK,    32'h0}},
    '{CMD_INSERT_AT,  6'd3,  32'h5a5a_5a5a, 1'b0, '0},
    '{CMD_POP_END,    6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE_AT,  6'd3,  32'h0000_0000, 1'b1, '{7'd3, ST_RANGE, 32'h0}},
    '{CMD_REMOVE_AT,  6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE_MID, 6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_APPEND,     6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_INSERT_MID, 6'd0,  32'ha5a5_a5a5, 1'b0, '0},
    '{CMD_POP_END,    6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP_END,    6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP_END,    6'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP_END,    6'd0,  32'h0000_0000, 1'b0, '0}
  };

  shifting_list_store #(
    .CAPACITY(LIST_CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic status_e insert_word(int unsigned idx, logic [WORD_W-1:0] word);
    int unsigned i;
    if (idx > list_len) return ST_RANGE;
    if (list_len >= LIST_CAPACITY) return ST_FULL;
    for (i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
    list_words[idx] = word;
    list_len++;
    return ST_OK;
  endfunction

  function automatic status_e remove_word(int unsigned idx);
    int unsigned i;
    if (idx >= list_len) return ST_RANGE;
    for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
    return ST_OK;
  endfunction

  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                       logic [POS_W-1:0] pos,
                                                       logic [WORD_W-1:0] word);
    list_result_t res;
    res = '{element_count: '0, status: ST_OK, popped_value: '0};
    case (cmd)
      CMD_APPEND:     res.status = insert_word(list_len, word);
      CMD_POP_END: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_len--;
          res.popped_value = list_words[list_len];
        end
      end
      CMD_INSERT_AT:  res.status = insert_word(32'(pos), word);
      CMD_REMOVE_AT:  res.status = remove_word(32'(pos));
      CMD_INSERT_MID: res.status = insert_word(list_len / 2, word);
      CMD_REMOVE_MID: res.status = remove_word(list_len / 2);
      default: ;
    endcase
    res.element_count = list_len[OCOUNT_W-1:0];
    return res;
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word, input logic typed,
                              input list_result_t want);
    int unsigned  gap;
    list_result_t predicted;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, word, pos, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_list_command(cmd, pos, word);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_list_settled();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // result side: random back-pressure per item, compare with oldest expectation
  initial begin : result_sink
    list_result_t got;
    list_result_t want;
    int unsigned  stall;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = list_result_t'(m_axis_tdata[40:0]);
      if (expected_results.size() == 0) begin
        $error("unexpected result item: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.popped_value !== want.popped_value) begin
          $error("popped_value: expected %h, got %h", want.popped_value, got.popped_value);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.element_count !== want.element_count) begin
          $error("element_count: expected %0d, got %0d", want.element_count,
                 got.element_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       row;
    int unsigned       sent;
    int unsigned       pick;
    bit                filling;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    list_len    = 0;
    src_burst   = 1'b0;
    filling     = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < N_ROWS; row++) begin
      send_command(directed_rows[row].cmd, directed_rows[row].position,
                   directed_rows[row].item_value, directed_rows[row].typed,
                   directed_rows[row].want);
    end
    wait_list_settled();

    // runs that fill the list to full and drain it to empty, with noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (list_len == LIST_CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (list_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        cmd = pick[0] ? CMD_SPARE_LO : CMD_SPARE_HI;
      end else if ((pick < 78) == filling) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_APPEND;
          1:       cmd = CMD_INSERT_AT;
          default: cmd = CMD_INSERT_MID;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_POP_END;
          1:       cmd = CMD_REMOVE_AT;
          default: cmd = CMD_REMOVE_MID;
        endcase
      end
      if (list_len == 0 || $urandom_range(0, 4) == 0)
        pos = POS_W'($urandom_range(0, 63));
      else
        pos = POS_W'($urandom_range(0, (list_len > 63) ? 63 : list_len));
      word = $urandom();
      send_command(cmd, pos, word, 1'b0, '0);
      if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) sent++;
      if (sent % DRAIN_EVERY == 0) wait_list_settled();
    end

    wait_list_settled();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sls_pkg.sv
hw/rtl/sls_cell.sv
hw/rtl/shifting_list_store.sv
bench/tb.sv
